/* design/mspid_pkg.sv */
// ----------------------------------------------------------------------------
// mspid_pkg: shared types and constants
// Fixed-point constants, register codes and the multiplier request type of the
// motor speed PID with tachometer.
// ----------------------------------------------------------------------------
package mspid_pkg;

   localparam int Q_FRAC   = 16;
   localparam int THR_W    = 9;
   localparam int SPB_W    = 16;
   localparam int SPEED_W  = 31;
   localparam int GAIN_W   = 32;
   localparam int DRIVE_W  = 17;
   localparam int BIN_W    = 16;
   localparam int MUL_W    = 33;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BIN_W-1:0]   BIN_MAX   = 16'hFFFF;
   localparam logic [DRIVE_W-1:0] DRIVE_MIN = 17'd6554;
   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 17'd65536;
   localparam logic signed [31:0] DEADZONE  = 32'sd66;
   // largest u that still fits within 1.00 after the 0.10 offset
   localparam logic signed [31:0] U_CLAMP   = 32'sd58982;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CLOSE_THR  = 3'd0,
      REG_FAR_THR    = 3'd1,
      REG_SPB        = 3'd2,
      REG_SCALE      = 3'd3,
      REG_TARGET     = 3'd4,
      REG_KP         = 3'd5,
      REG_KI         = 3'd6,
      REG_KD         = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [MUL_W-1:0] op_a;
      logic signed [MUL_W-1:0] op_b;
      logic                    shift;
   } mul_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

/* design/mspid_mul.sv */
// ----------------------------------------------------------------------------
// mspid_mul: shared multiplier
// One registered signed product; after the register, an optional Q16.16
// floor shift and saturation to signed 32 bits.
// ----------------------------------------------------------------------------
module mspid_mul import mspid_pkg::*; (
   input  logic               clock,
   input  mul_req_type        req,
   output logic signed [31:0] mul_result
);

   localparam int PROD_W = 2 * MUL_W;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     shift_ff;
   logic signed [PROD_W-1:0] scaled;
   logic [PROD_W-32:0]       upper;

   assign prod_in = $signed(req.op_a) * $signed(req.op_b);

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      shift_ff <= req.shift;
   end

   // arithmetic shift rounds toward minus infinity
   always_comb begin
      scaled = shift_ff ? (prod_ff >>> Q_FRAC) : prod_ff;
      upper  = scaled[PROD_W-1:31];
      if ((&upper) || !(|upper)) begin
         mul_result = scaled[31:0];
      end else if (scaled[PROD_W-1]) begin
         mul_result = 32'sh8000_0000;
      end else begin
         mul_result = 32'sh7FFF_FFFF;
      end
   end

endmodule

/* design/mspid_bins.sv */
// ----------------------------------------------------------------------------
// mspid_bins: revolution count bins
// Bin memory with one write and one registered read port; per-entry valid
// bits make unwritten bins read as zero after reset.
// ----------------------------------------------------------------------------
module mspid_bins import mspid_pkg::*; #(
   parameter int BINS  = 16,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [BIN_W-1:0] wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [BIN_W-1:0] rd_data
);

   logic [BIN_W-1:0] mem [BINS];
   logic [BINS-1:0]  valid_ff;
   logic [BIN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/motor_speed_pid_with_tachometer_core.sv */
// ----------------------------------------------------------------------------
// motor_speed_pid_with_tachometer_core: tachometer and PID speed regulator
// Hysteresis revolution counter over a ring of bins, followed by a Q16.16
// PID step and drive limiter, run on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sensor sample per transfer. req_ready is high only while the
//            sequencer is idle.
//   rsp_*  : one result per control step (every samples_per_bin samples):
//            PWM duty, measured speed and limited drive, held in an output
//            register until the receiver takes the transfer.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Sequence:
//   A sample that closes no bin passes through accept and bin update.
//   A sample that ends a bin goes on to the result register through bin
//   update, then six steps around the single 33x33 multiplier (speed,
//   integral, proportional and derivative products plus the sums),
//   then the limiter.
// Reset:
//   Clears the detector, bin ring, counters, integrator and registers to
//   their defaults; bins are cleared through valid bits.
// Stall:
//   A finished result waits in the output register; the next sample is still
//   taken, and a later result holds in the limiter step until the register
//   frees up.
// ----------------------------------------------------------------------------
module motor_speed_pid_with_tachometer_core import mspid_pkg::*; #(
   parameter int BINS        = 16,
   parameter int SAMPLE_BITS = 9,
   parameter int DUTY_BITS   = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sensor_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DUTY_BITS-1:0]   rsp_duty_value,
   output logic [SPEED_W-1:0]     rsp_measured_speed,
   output logic [DRIVE_W-1:0]     rsp_limited_drive,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W  = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int BSUM_W = $clog2(BINS * 65535 + 1);
   localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
   localparam logic [IDX_W-1:0]  LAST_BIN = IDX_W'(BINS - 1);
   localparam logic [BSUM_W-1:0] BSUM_MAX = BSUM_W'(BINS * 65535);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INC,
      S_FREQ,
      S_ERR,
      S_INTEG,
      S_PROP,
      S_DERIV,
      S_SUM,
      S_LIMIT
   } state_type;

   // configuration registers
   logic [THR_W-1:0]         close_thr_ff, close_thr_in;
   logic [THR_W-1:0]         far_thr_ff, far_thr_in;
   logic [SPB_W-1:0]         spb_ff, spb_in;
   logic [SPEED_W-1:0]       scale_ff, scale_in;
   logic [SPEED_W-1:0]       target_ff, target_in;
   logic signed [GAIN_W-1:0] kp_ff, kp_in;
   logic signed [GAIN_W-1:0] ki_ff, ki_in;
   logic signed [GAIN_W-1:0] kd_ff, kd_in;

   // sequencer and datapath state
   state_type                state_ff, state_in;
   logic                     close_ff, close_in;
   logic                     close_ev_ff, close_ev_in;
   logic [IDX_W-1:0]         newest_ff, newest_in;
   logic [BSUM_W-1:0]        bin_sum_ff, bin_sum_in;
   logic [SPB_W-1:0]         count_ff, count_in;
   logic signed [31:0]       prev_err_ff, prev_err_in;
   logic signed [31:0]       integ_ff, integ_in;
   logic [SPEED_W-1:0]       freq_ff, freq_in;
   logic signed [31:0]       err_ff, err_in;
   logic signed [31:0]       i_ff, i_in;
   logic signed [31:0]       diff_ff, diff_in;
   logic signed [33:0]       acc_ff, acc_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]     duty_ff, duty_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic [DRIVE_W-1:0]       drive_ff, drive_in;

   // shared units
   mul_req_type              mul_req;
   logic signed [31:0]       mul_result;
   logic                     bin_wr_en;
   logic [IDX_W-1:0]         bin_wr_addr;
   logic [BIN_W-1:0]         bin_wr_data;
   logic [IDX_W-1:0]         bin_rd_addr;
   logic [BIN_W-1:0]         bin_rd_data;

   // scratch
   logic [CMP_W-1:0]         sample_x;
   logic [SPB_W-1:0]         count_next;
   logic [SPB_W-1:0]         count_limit;
   logic [IDX_W-1:0]         next_bin;
   logic signed [31:0]       u_val;
   logic [DRIVE_W-1:0]       drive_val;
   logic [DRIVE_W+DUTY_BITS-1:0] duty_prod;

   mspid_mul u_mul (
      .clock      (clock),
      .req        (mul_req),
      .mul_result (mul_result)
   );

   mspid_bins #(
      .BINS  (BINS),
      .IDX_W (IDX_W)
   ) u_bins (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (bin_wr_data),
      .rd_addr (bin_rd_addr),
      .rd_data (bin_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign sample_x  = CMP_W'(req_sensor_sample);
   assign next_bin  = (newest_ff == LAST_BIN) ? '0 : newest_ff + 1'b1;
   assign count_next  = count_ff + 1'b1;
   assign count_limit = (spb_ff == '0) ? SPB_W'(1) : spb_ff;

   // limiter: dead zone, then offset by 0.10 and clamp at 1.00
   assign u_val = sat32(acc_ff);
   always_comb begin
      if (u_val < DEADZONE) begin
         drive_val = '0;
      end else if (u_val > U_CLAMP) begin
         drive_val = DRIVE_MAX;
      end else begin
         drive_val = u_val[DRIVE_W-1:0] + DRIVE_MIN;
      end
   end
   // drive * (2^DUTY_BITS - 1), then drop the 16 fraction bits
   assign duty_prod = ((DRIVE_W+DUTY_BITS)'(drive_val) << DUTY_BITS)
                      - (DRIVE_W+DUTY_BITS)'(drive_val);

   // configuration writes
   always_comb begin
      close_thr_in = close_thr_ff;
      far_thr_in   = far_thr_ff;
      spb_in       = spb_ff;
      scale_in     = scale_ff;
      target_in    = target_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_CLOSE_THR: close_thr_in = csr_wdata[THR_W-1:0];
            REG_FAR_THR:   far_thr_in   = csr_wdata[THR_W-1:0];
            REG_SPB:       spb_in       = csr_wdata[SPB_W-1:0];
            REG_SCALE:     scale_in     = csr_wdata[SPEED_W-1:0];
            REG_TARGET:    target_in    = csr_wdata[SPEED_W-1:0];
            REG_KP:        kp_in        = $signed(csr_wdata);
            REG_KI:        ki_in        = $signed(csr_wdata);
            REG_KD:        kd_in        = $signed(csr_wdata);
            default:       ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      close_in     = close_ff;
      close_ev_in  = close_ev_ff;
      newest_in    = newest_ff;
      bin_sum_in   = bin_sum_ff;
      count_in     = count_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      freq_in      = freq_ff;
      err_in       = err_ff;
      i_in         = i_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      duty_in      = duty_ff;
      speed_in     = speed_ff;
      drive_in     = drive_ff;

      mul_req      = '0;
      bin_wr_en    = 1'b0;
      bin_wr_addr  = newest_ff;
      bin_wr_data  = '0;
      bin_rd_addr  = newest_ff;

      case (state_ff)
         S_IDLE: begin
            // fetch the newest bin while the detector decides
            if (req_valid) begin
               close_ev_in = (sample_x < CMP_W'(close_thr_ff)) && !close_ff;
               if (close_ev_in) begin
                  close_in = 1'b1;
               end else if ((sample_x > CMP_W'(far_thr_ff)) && close_ff) begin
                  close_in = 1'b0;
               end
               state_in = S_INC;
            end
         end
         S_INC: begin
            // count the revolution unless the bin is full
            if (close_ev_ff && (bin_rd_data != BIN_MAX)) begin
               bin_wr_en   = 1'b1;
               bin_wr_data = bin_rd_data + 1'b1;
               bin_sum_in  = bin_sum_ff + 1'b1;
            end
            if ((count_next == '0) || (count_next >= count_limit)) begin
               count_in = '0;
               state_in = S_FREQ;
            end else begin
               count_in = count_next;
               state_in = S_IDLE;
            end
         end
         S_FREQ: begin
            // speed = bin sum * scale, unshifted; fetch the bin to drop
            mul_req.op_a  = MUL_W'(bin_sum_in);
            mul_req.op_b  = MUL_W'(scale_ff);
            mul_req.shift = 1'b0;
            bin_rd_addr   = next_bin;
            newest_in     = next_bin;
            state_in      = S_ERR;
         end
         S_ERR: begin
            freq_in       = mul_result[SPEED_W-1:0];
            bin_wr_en     = 1'b1;
            bin_wr_data   = '0;
            bin_sum_in    = bin_sum_ff - BSUM_W'(bin_rd_data);
            mul_req.op_a  = MUL_W'(ki_ff);
            mul_req.op_b  = MUL_W'(prev_err_ff);
            mul_req.shift = 1'b1;
            state_in      = S_INTEG;
         end
         S_INTEG: begin
            err_in   = sat32(34'(signed'({1'b0, target_ff}))
                             - 34'(signed'({1'b0, freq_ff})));
            i_in     = sat32(34'(integ_ff) + 34'(mul_result));
            state_in = S_PROP;
         end
         S_PROP: begin
            diff_in       = sat32(34'(err_ff) - 34'(prev_err_ff));
            mul_req.op_a  = MUL_W'(kp_ff);
            mul_req.op_b  = MUL_W'(err_ff);
            mul_req.shift = 1'b1;
            state_in      = S_DERIV;
         end
         S_DERIV: begin
            acc_in        = 34'(mul_result) + 34'(i_ff);
            mul_req.op_a  = MUL_W'(kd_ff);
            mul_req.op_b  = MUL_W'(diff_ff);
            mul_req.shift = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            acc_in      = acc_ff + 34'(mul_result);
            prev_err_in = err_ff;
            integ_in    = i_ff;
            state_in    = S_LIMIT;
         end
         S_LIMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               duty_in      = duty_prod[Q_FRAC +: DUTY_BITS];
               speed_in     = freq_ff;
               drive_in     = drive_val;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         close_ff     <= 1'b0;
         close_ev_ff  <= 1'b0;
         newest_ff    <= '0;
         bin_sum_ff   <= '0;
         count_ff     <= '0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         close_thr_ff <= '0;
         far_thr_ff   <= THR_W'(511);
         spb_ff       <= SPB_W'(1);
         scale_ff     <= SPEED_W'(65536);
         target_ff    <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         close_ff     <= close_in;
         close_ev_ff  <= close_ev_in;
         newest_ff    <= newest_in;
         bin_sum_ff   <= bin_sum_in;
         count_ff     <= count_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
         close_thr_ff <= close_thr_in;
         far_thr_ff   <= far_thr_in;
         spb_ff       <= spb_in;
         scale_ff     <= scale_in;
         target_ff    <= target_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
      end
      freq_ff  <= freq_in;
      err_ff   <= err_in;
      i_ff     <= i_in;
      diff_ff  <= diff_in;
      acc_ff   <= acc_in;
      duty_ff  <= duty_in;
      speed_ff <= speed_in;
      drive_ff <= drive_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_duty_value     = duty_ff;
   assign rsp_measured_speed = speed_ff;
   assign rsp_limited_drive  = drive_ff;

   // a held result is either off or within the 0.10 to 1.00 band
   a_drive_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_ff == '0)
                       || ((drive_ff >= DRIVE_MIN) && (drive_ff <= DRIVE_MAX)))
      else $error("limited drive outside its band");

   // zero drive must give zero duty
   a_duty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (drive_ff == '0)) |-> (duty_ff == '0))
      else $error("duty nonzero with zero drive");

   // a new result only comes out of the limiter step
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LIMIT))
      else $error("result raised outside the limiter step");

   // running bin sum never exceeds every bin full
   a_bin_sum: assert property (@(posedge clock) disable iff (reset)
      bin_sum_ff <= BSUM_MAX)
      else $error("bin sum out of range");

endmodule
